FILE: rtl/hrlc_pkg.sv
`default_nettype none

package hrlc_pkg;

   localparam int unsigned MAX_LINE_DEFAULT = 4096;
   localparam int unsigned CLASS_QUEUE_DEPTH = 4;
   localparam int unsigned RESULT_QUEUE_DEPTH = 2;

   localparam int unsigned OFFSET_WIDTH = 12;
   localparam int unsigned LENGTH_WIDTH = 13;

   localparam int unsigned METHOD_LEN = 3;
   localparam int unsigned VERSION_LEN = 8;

   localparam logic [7:0] SPACE_BYTE = 8'h20;
   localparam logic [7:0] METHOD_WORD [METHOD_LEN] = '{8'h47, 8'h45, 8'h54};
   localparam logic [7:0] VERSION_WORD [VERSION_LEN] =
      '{8'h48, 8'h54, 8'h54, 8'h50, 8'h2f, 8'h31, 8'h2e, 8'h31};

   localparam logic [2:0] TOKEN_METHOD = 3'd1;
   localparam logic [2:0] TOKEN_PATH = 3'd2;
   localparam logic [2:0] TOKEN_VERSION = 3'd3;
   localparam logic [2:0] TOKEN_LIMIT = 3'd4;
   localparam logic [3:0] CHAR_LIMIT = 4'd9;

   typedef enum logic [1:0] {
      STATUS_OK = 2'd0,
      STATUS_BAD_REQUEST = 2'd1,
      STATUS_NOT_IMPLEMENTED = 2'd2,
      STATUS_VERSION_NOT_SUPPORTED = 2'd3
   } status_type;

   typedef struct packed {
      logic is_space;
      logic last;
      logic [METHOD_LEN-1:0] method_hit;
      logic [VERSION_LEN-1:0] version_hit;
   } class_type;

   typedef struct packed {
      status_type status;
      logic [OFFSET_WIDTH-1:0] path_offset;
      logic [LENGTH_WIDTH-1:0] path_length;
   } result_type;

endpackage

`default_nettype wire

FILE: rtl/hrlc_fifo.sv
`default_nettype none

module hrlc_fifo #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output      logic             full,
   input  wire logic             pop,
   output      logic [WIDTH-1:0] pop_data,
   output      logic             empty
);
   // DEPTH must be a power of two so that the pointers wrap on their own.
   localparam int unsigned PTR_WIDTH = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_WIDTH = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     mem_ff [DEPTH];
   logic [PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign full = (count_ff == CNT_WIDTH'(DEPTH));
   assign empty = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (do_push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/hrlc_front.sv
`default_nettype none

module hrlc_front (
   input  wire logic [7:0]         line_byte,
   input  wire logic               end_of_line,
   output      hrlc_pkg::class_type byte_class
);
   import hrlc_pkg::*;

   always_comb begin
      byte_class.is_space = (line_byte == SPACE_BYTE);
      byte_class.last = end_of_line;
      for (int k = 0; k < METHOD_LEN; k++) begin
         byte_class.method_hit[k] = (line_byte == METHOD_WORD[k]);
      end
      for (int k = 0; k < VERSION_LEN; k++) begin
         byte_class.version_hit[k] = (line_byte == VERSION_WORD[k]);
      end
   end

endmodule

`default_nettype wire

FILE: rtl/hrlc_back.sv
`default_nettype none

module hrlc_back #(
   parameter int unsigned MAX_LINE = hrlc_pkg::MAX_LINE_DEFAULT
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 class_valid,
   input  wire hrlc_pkg::class_type  byte_class,
   output      logic                 class_pop,
   input  wire logic                 result_full,
   output      logic                 result_push,
   output      hrlc_pkg::result_type result
);
   import hrlc_pkg::*;

   localparam int unsigned POS_WIDTH = $clog2(MAX_LINE + 1);
   localparam int unsigned START_WIDTH = $clog2(MAX_LINE);

   logic [2:0]             token_count_ff, token_count_in;
   logic                   inside_token_ff, inside_token_in;
   logic [3:0]             char_in_token_ff, char_in_token_in;
   logic                   method_matches_ff, method_matches_in;
   logic                   version_matches_ff, version_matches_in;
   logic [POS_WIDTH-1:0]   byte_position_ff, byte_position_in;
   logic [START_WIDTH-1:0] path_start_ff, path_start_in;
   logic [POS_WIDTH-1:0]   path_len_ff, path_len_in;
   logic                   too_long_ff, too_long_in;

   always_comb begin
      logic [2:0] count;
      logic [3:0] index;
      logic       method_ok;
      logic       version_ok;

      token_count_in = token_count_ff;
      inside_token_in = inside_token_ff;
      char_in_token_in = char_in_token_ff;
      method_matches_in = method_matches_ff;
      version_matches_in = version_matches_ff;
      byte_position_in = byte_position_ff;
      path_start_in = path_start_ff;
      path_len_in = path_len_ff;
      too_long_in = too_long_ff;
      count = token_count_ff;
      index = char_in_token_ff;
      method_ok = 1'b0;
      version_ok = 1'b0;
      result_push = 1'b0;
      result.status = STATUS_OK;
      result.path_offset = '0;
      result.path_length = '0;

      class_pop = class_valid && !result_full;

      if (class_pop) begin
         if (byte_position_ff >= POS_WIDTH'(MAX_LINE)) begin
            too_long_in = 1'b1;
         end else begin
            byte_position_in = byte_position_ff + 1'b1;
            if (byte_class.is_space) begin
               if (inside_token_ff) begin
                  if (token_count_ff == TOKEN_METHOD && char_in_token_ff != 4'(METHOD_LEN)) begin
                     method_matches_in = 1'b0;
                  end
                  if (token_count_ff == TOKEN_VERSION
                      && char_in_token_ff != 4'(VERSION_LEN)) begin
                     version_matches_in = 1'b0;
                  end
               end
               inside_token_in = 1'b0;
            end else begin
               if (!inside_token_ff) begin
                  inside_token_in = 1'b1;
                  index = '0;
                  if (count < TOKEN_LIMIT) begin
                     count = count + 1'b1;
                  end
                  if (count == TOKEN_PATH) begin
                     path_start_in = byte_position_ff[START_WIDTH-1:0];
                  end
               end
               if (count == TOKEN_METHOD) begin
                  if (index >= 4'(METHOD_LEN) || !byte_class.method_hit[index[1:0]]) begin
                     method_matches_in = 1'b0;
                  end
               end else if (count == TOKEN_VERSION) begin
                  if (index >= 4'(VERSION_LEN) || !byte_class.version_hit[index[2:0]]) begin
                     version_matches_in = 1'b0;
                  end
               end else if (count == TOKEN_PATH) begin
                  path_len_in = path_len_ff + 1'b1;
               end
               token_count_in = count;
               char_in_token_in = (index < CHAR_LIMIT) ? index + 1'b1 : index;
            end
         end

         if (byte_class.last) begin
            method_ok = method_matches_in;
            version_ok = version_matches_in;
            if (inside_token_in) begin
               if (token_count_in == TOKEN_METHOD && char_in_token_in != 4'(METHOD_LEN)) begin
                  method_ok = 1'b0;
               end
               if (token_count_in == TOKEN_VERSION && char_in_token_in != 4'(VERSION_LEN)) begin
                  version_ok = 1'b0;
               end
            end
            result_push = 1'b1;
            if (too_long_in || token_count_in != TOKEN_VERSION) begin
               result.status = STATUS_BAD_REQUEST;
            end else if (!method_ok) begin
               result.status = STATUS_NOT_IMPLEMENTED;
            end else if (!version_ok) begin
               result.status = STATUS_VERSION_NOT_SUPPORTED;
            end else begin
               result.status = STATUS_OK;
               result.path_offset = OFFSET_WIDTH'(path_start_in);
               result.path_length = LENGTH_WIDTH'(path_len_in);
            end
            token_count_in = '0;
            inside_token_in = 1'b0;
            char_in_token_in = '0;
            method_matches_in = 1'b1;
            version_matches_in = 1'b1;
            byte_position_in = '0;
            path_start_in = '0;
            path_len_in = '0;
            too_long_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_count_ff <= '0;
         inside_token_ff <= 1'b0;
         char_in_token_ff <= '0;
         method_matches_ff <= 1'b1;
         version_matches_ff <= 1'b1;
         byte_position_ff <= '0;
         path_start_ff <= '0;
         path_len_ff <= '0;
         too_long_ff <= 1'b0;
      end else begin
         token_count_ff <= token_count_in;
         inside_token_ff <= inside_token_in;
         char_in_token_ff <= char_in_token_in;
         method_matches_ff <= method_matches_in;
         version_matches_ff <= version_matches_in;
         byte_position_ff <= byte_position_in;
         path_start_ff <= path_start_in;
         path_len_ff <= path_len_in;
         too_long_ff <= too_long_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/http_request_line_checker.sv
`default_nettype none

// Channel   Handshake              Payload
// req       push / full            req_line_byte, req_end_of_line
// rsp       empty / pop            rsp_status, rsp_path_offset, rsp_path_length
//
// One byte word is taken per cycle while full is low.
// A word is registered in the class queue; the back end judges it and pushes the
// result into the result queue, from which it shows on the rsp ports and can be popped.
// Reset is synchronous and empties both queues and clears the line state.
// A stalled result only stalls the back end once the result queue fills.

module http_request_line_checker #(
   parameter int unsigned MAX_LINE = hrlc_pkg::MAX_LINE_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output      logic                              req_full,
   input  wire logic [7:0]                        req_line_byte,
   input  wire logic                              req_end_of_line,
   output      logic                              rsp_empty,
   input  wire logic                              rsp_pop,
   output      logic [1:0]                        rsp_status,
   output      logic [hrlc_pkg::OFFSET_WIDTH-1:0] rsp_path_offset,
   output      logic [hrlc_pkg::LENGTH_WIDTH-1:0] rsp_path_length
);
   import hrlc_pkg::*;

   class_type  front_class;
   class_type  back_class;
   logic       class_empty;
   logic       class_pop;
   logic       result_full;
   logic       result_push;
   result_type back_result;
   result_type out_result;

   hrlc_front u_front (
      .line_byte   (req_line_byte),
      .end_of_line (req_end_of_line),
      .byte_class  (front_class)
   );

   hrlc_fifo #(
      .WIDTH ($bits(class_type)),
      .DEPTH (CLASS_QUEUE_DEPTH)
   ) u_class_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_class),
      .full      (req_full),
      .pop       (class_pop),
      .pop_data  (back_class),
      .empty     (class_empty)
   );

   hrlc_back #(
      .MAX_LINE (MAX_LINE)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .class_valid (!class_empty),
      .byte_class  (back_class),
      .class_pop   (class_pop),
      .result_full (result_full),
      .result_push (result_push),
      .result      (back_result)
   );

   hrlc_fifo #(
      .WIDTH ($bits(result_type)),
      .DEPTH (RESULT_QUEUE_DEPTH)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_push),
      .push_data (back_result),
      .full      (result_full),
      .pop       (rsp_pop),
      .pop_data  (out_result),
      .empty     (rsp_empty)
   );

   assign rsp_status = out_result.status;
   assign rsp_path_offset = out_result.path_offset;
   assign rsp_path_length = out_result.path_length;

endmodule

`default_nettype wire

FILE: rtl/hrlc_checker.sv
`default_nettype none

module hrlc_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_push,
   input wire logic                              req_full,
   input wire logic [7:0]                        req_line_byte,
   input wire logic                              req_end_of_line,
   input wire logic                              rsp_empty,
   input wire logic                              rsp_pop,
   input wire logic [1:0]                        rsp_status,
   input wire logic [hrlc_pkg::OFFSET_WIDTH-1:0] rsp_path_offset,
   input wire logic [hrlc_pkg::LENGTH_WIDTH-1:0] rsp_path_length
);
   import hrlc_pkg::*;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty && $stable(rsp_status)
         && $stable(rsp_path_offset) && $stable(rsp_path_length))
      else $error("waiting result word changed");

   a_error_no_path: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status != STATUS_OK) |-> rsp_path_offset == '0
         && rsp_path_length == '0)
      else $error("error status carries a path");

   a_ok_has_path: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_status == STATUS_OK) |-> rsp_path_length != '0
         && rsp_path_offset >= OFFSET_WIDTH'(METHOD_LEN + 1))
      else $error("ok status without a valid path");

endmodule

bind http_request_line_checker hrlc_checker u_hrlc_checker (.*);

`default_nettype wire

FILE: sim/tb_http_request_line_checker.sv
`default_nettype none

module tb_http_request_line_checker;

   timeunit 1ns;
   timeprecision 1ps;

   import hrlc_pkg::*;

   localparam int unsigned LINE_LIMIT = MAX_LINE_DEFAULT;
   localparam int unsigned CYCLE_LIMIT = 600000;
   localparam int unsigned SETTLE_CYCLES = 20;

   logic clock = 1'b0;
   logic reset;
   logic req_push;
   logic req_full;
   logic [7:0] req_line_byte;
   logic req_end_of_line;
   logic rsp_empty;
   logic rsp_pop;
   logic [1:0] rsp_status;
   logic [OFFSET_WIDTH-1:0] rsp_path_offset;
   logic [LENGTH_WIDTH-1:0] rsp_path_length;

   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int fail_count = 0;
   int cycle_count = 0;

   // Parser state that mirrors the block, advanced on every accepted word.
   logic [2:0] tok_count;
   logic in_tok;
   logic [3:0] tok_chars;
   logic method_ok;
   logic version_ok;
   logic [12:0] line_pos;
   logic [OFFSET_WIDTH-1:0] path_at;
   logic [LENGTH_WIDTH-1:0] path_bytes;
   logic overlong;

   result_type awaited_verdicts[$];
   logic [7:0] line_text[$];

   http_request_line_checker dut (
      .clock(clock),
      .reset(reset),
      .req_push(req_push),
      .req_full(req_full),
      .req_line_byte(req_line_byte),
      .req_end_of_line(req_end_of_line),
      .rsp_empty(rsp_empty),
      .rsp_pop(rsp_pop),
      .rsp_status(rsp_status),
      .rsp_path_offset(rsp_path_offset),
      .rsp_path_length(rsp_path_length)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function void clear_line_state();
      tok_count = '0;
      in_tok = 1'b0;
      tok_chars = '0;
      method_ok = 1'b1;
      version_ok = 1'b1;
      line_pos = '0;
      path_at = '0;
      path_bytes = '0;
      overlong = 1'b0;
   endfunction

   function void close_current_token();
      if (in_tok) begin
         if (tok_count == TOKEN_METHOD && tok_chars != 4'(METHOD_LEN)) begin
            method_ok = 1'b0;
         end
         if (tok_count == TOKEN_VERSION && tok_chars != 4'(VERSION_LEN)) begin
            version_ok = 1'b0;
         end
         in_tok = 1'b0;
      end
   endfunction

   function void absorb_line_byte(input logic [7:0] data);
      if (data == SPACE_BYTE) begin
         close_current_token();
      end else begin
         if (!in_tok) begin
            in_tok = 1'b1;
            tok_chars = '0;
            if (tok_count < TOKEN_LIMIT) begin
               tok_count = tok_count + 3'd1;
            end
            if (tok_count == TOKEN_PATH) begin
               path_at = line_pos[OFFSET_WIDTH-1:0];
            end
         end
         if (tok_count == TOKEN_METHOD) begin
            if (tok_chars >= 4'(METHOD_LEN)) begin
               method_ok = 1'b0;
            end else if (data != METHOD_WORD[tok_chars]) begin
               method_ok = 1'b0;
            end
         end else if (tok_count == TOKEN_VERSION) begin
            if (tok_chars >= 4'(VERSION_LEN)) begin
               version_ok = 1'b0;
            end else if (data != VERSION_WORD[tok_chars]) begin
               version_ok = 1'b0;
            end
         end else if (tok_count == TOKEN_PATH) begin
            path_bytes = path_bytes + 1'b1;
         end
         if (tok_chars < CHAR_LIMIT) begin
            tok_chars = tok_chars + 4'd1;
         end
      end
   endfunction

   function automatic logic judge_line_word(input logic [7:0] data, input logic eol,
                                            output result_type verdict);
      if (line_pos >= LINE_LIMIT) begin
         overlong = 1'b1;
      end else begin
         absorb_line_byte(data);
         line_pos = line_pos + 13'd1;
      end
      verdict = '0;
      if (!eol) begin
         return 1'b0;
      end
      close_current_token();
      if (overlong || tok_count != TOKEN_VERSION) begin
         verdict.status = STATUS_BAD_REQUEST;
      end else if (!method_ok) begin
         verdict.status = STATUS_NOT_IMPLEMENTED;
      end else if (!version_ok) begin
         verdict.status = STATUS_VERSION_NOT_SUPPORTED;
      end else begin
         verdict.status = STATUS_OK;
         verdict.path_offset = path_at;
         verdict.path_length = path_bytes;
      end
      clear_line_state();
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      result_type verdict;
      result_type oldest;
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else if (reset) begin
         clear_line_state();
      end else begin
         if (req_push && !req_full) begin
            if (judge_line_word(req_line_byte, req_end_of_line, verdict)) begin
               awaited_verdicts.push_back(verdict);
            end
         end
         if (rsp_pop && !rsp_empty) begin
            if (awaited_verdicts.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual status %0d",
                        $time, rsp_status);
               fail_count = fail_count + 1;
            end else begin
               oldest = awaited_verdicts.pop_front();
               if (rsp_status != oldest.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, oldest.status, rsp_status);
                  fail_count = fail_count + 1;
               end
               if (rsp_path_offset != oldest.path_offset) begin
                  $display("%0t: path_offset expected %0d actual %0d",
                           $time, oldest.path_offset, rsp_path_offset);
                  fail_count = fail_count + 1;
               end
               if (rsp_path_length != oldest.path_length) begin
                  $display("%0t: path_length expected %0d actual %0d",
                           $time, oldest.path_length, rsp_path_length);
                  fail_count = fail_count + 1;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= receiver_idle_pct);
   end

   task automatic send_word(input logic [7:0] data, input logic eol);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_line_byte <= data;
      req_end_of_line <= eol;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_line();
      foreach (line_text[i]) begin
         send_word(line_text[i], i == line_text.size() - 1);
      end
      line_text.delete();
   endtask

   function automatic logic [7:0] random_token_byte();
      logic [7:0] v;
      do begin
         v = 8'($urandom_range(1, 255));
      end while (v == SPACE_BYTE);
      return v;
   endfunction

   function automatic void append_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         line_text.push_back(s[i]);
      end
   endfunction

   function automatic void append_spaces(input int n);
      repeat (n) line_text.push_back(SPACE_BYTE);
   endfunction

   function automatic void append_random_token(input int n);
      repeat (n) line_text.push_back(random_token_byte());
   endfunction

   // A keyword, a near miss of it (cut short, one byte too many, one byte changed) or a random token.
   function automatic void append_keyword(input string w);
      int pick;
      int at;
      logic [7:0] swapped;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         append_text(w);
      end else if (pick == 6) begin
         append_text(w.substr(0, w.len() - 2));
      end else if (pick == 7) begin
         append_text(w);
         line_text.push_back(random_token_byte());
      end else if (pick == 8) begin
         at = $urandom_range(0, w.len() - 1);
         do begin
            swapped = random_token_byte();
         end while (swapped == w[at]);
         for (int i = 0; i < w.len(); i++) begin
            line_text.push_back(i == at ? swapped : w[i]);
         end
      end else begin
         append_random_token($urandom_range(1, 10));
      end
   endfunction

   function automatic void build_request_line();
      int kind;
      int tokens;
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
         repeat ($urandom_range(1, 20)) begin
            line_text.push_back($urandom_range(0, 3) == 0 ? SPACE_BYTE : random_token_byte());
         end
      end else begin
         tokens = (kind < 8) ? 3 : $urandom_range(0, 5);
         if ($urandom_range(0, 3) == 0) begin
            append_spaces($urandom_range(1, 3));
         end
         for (int t = 0; t < tokens; t++) begin
            if (t > 0) begin
               append_spaces($urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 1);
            end
            if (t == 0) begin
               append_keyword("GET");
            end else if (t == 1) begin
               line_text.push_back($urandom_range(0, 4) == 0 ? random_token_byte() : "/");
               append_random_token($urandom_range(0, 12));
            end else if (t == 2) begin
               append_keyword("HTTP/1.1");
            end else begin
               append_random_token($urandom_range(1, 6));
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            append_spaces($urandom_range(1, 3));
         end
      end
      if (line_text.size() == 0) begin
         line_text.push_back(SPACE_BYTE);
      end
   endfunction

   task automatic test_edge_lines();
      append_text(" GET / HTTP/1.1 ");
      send_line();
      append_spaces(1);
      send_line();
      line_text.push_back(8'h00);
      send_line();
      line_text.push_back(8'hff);
      send_line();
   endtask

   task automatic test_random_lines(input int min_words, input int min_lines);
      int words;
      int lines;
      words = 0;
      lines = 0;
      while (words < min_words || lines < min_lines) begin
         build_request_line();
         words += line_text.size();
         lines++;
         send_line();
      end
   endtask

   initial begin
      reset <= 1'b1;
      req_push <= 1'b0;
      req_line_byte <= '0;
      req_end_of_line <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      sender_idle_pct = 19;
      receiver_idle_pct = 67;
      test_edge_lines();
      test_random_lines(300, 10);

      sender_idle_pct = 67;
      receiver_idle_pct = 19;
      test_random_lines(300, 10);

      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      test_random_lines(300, 10);

      req_push <= 1'b0;
      while (awaited_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
